// ===== src/upsru_pkg.sv =====
// upsru_pkg: shared types, widths and codes of the unknown protocol report sampler
// used by upsru_cell, upsru_rem and the top level; no dependencies
package upsru_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 32;
  localparam int ANA_W         = 8;
  localparam int PROT_W        = 32;
  localparam int LEN_W         = 16;
  localparam int TIME_W        = 32;
  localparam int RATE_W        = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int STATUS_W      = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TICK = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic              tick;
    logic              report;
    logic              any_hit;
    logic [ANA_W-1:0]  analyzer;
    logic [PROT_W-1:0] protocol;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] expiry;
  } cell_cmd_t;

  // search state handed from one cell to the next
  typedef struct packed {
    logic                  hit_seen;
    logic                  free_seen;
    logic [COUNT_BITS-1:0] count;
  } chain_t;

endpackage

// ===== src/upsru_cell.sv =====
// upsru_cell: one table entry of the sampler with its key compare and count update
// depends on upsru_pkg
module upsru_cell (
  input  logic               clk,
  input  logic               rst,
  input  upsru_pkg::cell_cmd_t cmd,
  input  upsru_pkg::chain_t  link_in,
  output upsru_pkg::chain_t  link_out
);

  logic                                valid;
  logic [upsru_pkg::ANA_W-1:0]         analyzer;
  logic [upsru_pkg::PROT_W-1:0]        protocol;
  logic [upsru_pkg::COUNT_BITS-1:0]    count;
  logic [upsru_pkg::TIME_W-1:0]        expiry;
  logic                                key_eq;
  logic                                sel_hit;
  logic                                sel_free;

  // lowest matching entry and lowest free entry win
  assign key_eq   = valid && (analyzer == cmd.analyzer) && (protocol == cmd.protocol);
  assign sel_hit  = key_eq && !link_in.hit_seen;
  assign sel_free = !valid && !link_in.free_seen;

  assign link_out.hit_seen  = link_in.hit_seen | key_eq;
  assign link_out.free_seen = link_in.free_seen | !valid;
  assign link_out.count     = link_in.count | (sel_hit ? count : '0);

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.tick && valid && (cmd.now >= expiry)) begin
      valid <= 1'b0;
    end else if (cmd.report && sel_free && !cmd.any_hit) begin
      valid <= 1'b1;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (cmd.report && sel_hit && (count != upsru_pkg::COUNT_MAX)) begin
      count <= count + 1'b1;
    end else if (cmd.report && sel_free && !cmd.any_hit) begin
      analyzer <= cmd.analyzer;
      protocol <= cmd.protocol;
      count    <= {{(upsru_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
      expiry   <= cmd.expiry;
    end
  end

endmodule

// ===== src/upsru_rem.sv =====
// upsru_rem: bit-serial remainder unit, one dividend bit per cycle
// depends on upsru_pkg
module upsru_rem (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [upsru_pkg::COUNT_BITS-1:0] dividend,
  input  logic [upsru_pkg::RATE_W-1:0]     divisor,
  output logic                             busy,
  output logic                             done,
  output logic                             rem_zero
);

  localparam int CNT_W = $clog2(upsru_pkg::COUNT_BITS + 1);

  logic [upsru_pkg::COUNT_BITS-1:0] dvd;
  logic [upsru_pkg::RATE_W-1:0]     dsr;
  logic [upsru_pkg::RATE_W-1:0]     rem;
  logic [CNT_W-1:0]                 cnt;
  logic [upsru_pkg::RATE_W:0]       trial;

  assign trial    = {rem, dvd[upsru_pkg::COUNT_BITS-1]};
  assign rem_zero = (rem == '0);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(upsru_pkg::COUNT_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (trial >= {1'b0, dsr}) begin
        rem <= upsru_pkg::RATE_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[upsru_pkg::RATE_W-1:0];
      end
    end
  end

endmodule

// ===== src/unknown_protocol_report_sampler_unit.sv =====
// Usage: unknown protocol report sampler. Input items arrive on s_tvalid/s_tready
// with s_tuser = request kind (0 report, 1 tick) and s_tdata = key, length, time.
// Each item gives exactly one result on m_tvalid/m_tready: m_tuser = status
// (0 ok, 1 table full, 2 tick done), m_tdata = permit and bytes to send.
// Registers are written on cfg_valid/cfg_ready (always ready) by index.
// A tick or a report that resolves without sampling goes from acceptance through
// S_LOOK and S_DONE to m_tvalid; a report at or past the threshold with a nonzero
// rate waits in S_DIV on the bit-serial remainder unit (one count bit per cycle).
// One item is handled at a time; s_tready is high only while idle, so a new item
// is taken only after the last one has left S_DONE for the output register.
// The table is a row of 64 cells searched combinationally; the lowest matching
// or lowest free cell takes the report.
// Reset (rst, synchronous) clears config, state and m_tvalid and empties the table.
// When m_tready is low the finished result is held in the output register
// and a finished next item waits until that result is taken.
// depends on upsru_pkg, upsru_cell, upsru_rem
module unknown_protocol_report_sampler_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // analyzer_id[7:0], protocol_id[39:8], payload_len[55:40], now_ticks[87:56]
  input  logic [87:0]                          s_tdata,
  // req_type
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // permit[0], bytes_to_send[16:1], zero fill [23:17]
  output logic [23:0]                          m_tdata,
  // status
  output logic [upsru_pkg::STATUS_W-1:0]       m_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [upsru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [upsru_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration
  logic                             report_enable;
  logic [31:0]                      sample_threshold;
  logic [upsru_pkg::RATE_W-1:0]     sample_rate;
  logic [upsru_pkg::TIME_W-1:0]     window_ticks;
  logic [upsru_pkg::LEN_W-1:0]      first_bytes_limit;

  // held item
  logic                             req_type;
  logic [upsru_pkg::ANA_W-1:0]      analyzer_id;
  logic [upsru_pkg::PROT_W-1:0]     protocol_id;
  logic [upsru_pkg::LEN_W-1:0]      payload_len;
  logic [upsru_pkg::TIME_W-1:0]     now_ticks;

  // result under work
  logic                             permit;
  logic [upsru_pkg::STATUS_W-1:0]   status;
  logic                             permit_out;
  logic [upsru_pkg::LEN_W-1:0]      bytes_out;

  upsru_pkg::cell_cmd_t             cmd;
  upsru_pkg::chain_t                links [0:upsru_pkg::TABLE_ENTRIES];
  upsru_pkg::chain_t                tail;

  logic [upsru_pkg::COUNT_BITS-1:0] new_count;
  logic [upsru_pkg::COUNT_BITS-1:0] thr_ext;
  logic                             div_start;
  logic                             div_busy;
  logic                             div_done;
  logic                             div_zero;
  logic                             look_permit;
  logic [upsru_pkg::STATUS_W-1:0]   look_status;
  logic                             out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      report_enable     <= 1'b0;
      sample_threshold  <= '0;
      sample_rate       <= '0;
      window_ticks      <= '0;
      first_bytes_limit <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        upsru_pkg::REG_ENABLE:    report_enable     <= cfg_data[0];
        upsru_pkg::REG_THRESHOLD: sample_threshold  <= cfg_data;
        upsru_pkg::REG_RATE:      sample_rate       <= cfg_data[upsru_pkg::RATE_W-1:0];
        upsru_pkg::REG_WINDOW:    window_ticks      <= cfg_data;
        upsru_pkg::REG_LIMIT:     first_bytes_limit <= cfg_data[upsru_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_type    <= s_tuser;
      analyzer_id <= s_tdata[7:0];
      protocol_id <= s_tdata[39:8];
      payload_len <= s_tdata[55:40];
      now_ticks   <= s_tdata[87:56];
    end
  end

  // broadcast to the cell row
  always_comb begin
    cmd          = '0;
    cmd.tick     = (state == S_LOOK) && req_type;
    cmd.report   = (state == S_LOOK) && !req_type && report_enable;
    cmd.any_hit  = tail.hit_seen;
    cmd.analyzer = analyzer_id;
    cmd.protocol = protocol_id;
    cmd.now      = now_ticks;
    cmd.expiry   = now_ticks + window_ticks;
  end

  assign links[0] = '0;

  for (genvar g = 0; g < upsru_pkg::TABLE_ENTRIES; g++) begin : g_cell
    upsru_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  assign tail = links[upsru_pkg::TABLE_ENTRIES];

  // count after this report and the sampling decision
  assign thr_ext = upsru_pkg::COUNT_BITS'(sample_threshold);

  always_comb begin
    if (tail.hit_seen) begin
      new_count = (tail.count == upsru_pkg::COUNT_MAX) ? tail.count : tail.count + 1'b1;
    end else begin
      new_count = {{(upsru_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    look_permit = 1'b0;
    look_status = upsru_pkg::ST_OK;
    div_start   = 1'b0;
    if (req_type) begin
      look_status = upsru_pkg::ST_TICK;
    end else if (report_enable) begin
      if (!tail.hit_seen && tail.free_seen == 1'b0) begin
        look_status = upsru_pkg::ST_FULL;
      end else if (new_count < thr_ext) begin
        look_permit = 1'b1;
      end else if (sample_rate != '0) begin
        div_start = (state == S_LOOK);
      end
    end
  end

  upsru_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_count - thr_ext),
    .divisor  (sample_rate),
    .busy     (div_busy),
    .done     (div_done),
    .rem_zero (div_zero)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_LOOK;
      S_LOOK: state_next = div_start ? S_DIV : S_DONE;
      S_DIV:  if (div_done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result under work
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      permit <= look_permit;
      status <= look_status;
    end else if (state == S_DIV && div_done) begin
      permit <= div_zero;
    end
  end

  // output register
  assign bytes_out  = (payload_len < first_bytes_limit) ? payload_len : first_bytes_limit;
  assign permit_out = permit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {7'd0, (permit_out ? bytes_out : {upsru_pkg::LEN_W{1'b0}}), permit_out};
      m_tuser <= status;
    end
  end

`ifndef ASSERT_OFF
  a_div_runs : assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !div_done) |-> div_busy)
    else $error("remainder unit idle while sequencer waits on it");
  a_tick_denied : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == upsru_pkg::ST_TICK) |-> !m_tdata[0])
    else $error("tick result carries a permit");
  a_no_bytes : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[16:1] == '0))
    else $error("denied report carries bytes");
  a_div_from_look : assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == S_DIV))
    else $error("remainder started outside a sampled report");
`endif

endmodule
